FILE: hw/rtl/greedy_graph_coloring_top_macros.svh
// Assertion macros shared by the graph coloring RTL.
`ifndef GREEDY_GRAPH_COLORING_TOP_MACROS_SVH
`define GREEDY_GRAPH_COLORING_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define GGC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ggc assertion failed");

// Next-cycle implication, checked outside reset.
`define GGC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ggc assertion failed");

`endif

FILE: hw/rtl/ggc_pkg.sv
// Types and constants for the greedy graph coloring block.
`timescale 1ns / 1ps

package ggc_pkg;

    // Input command codes
    localparam logic [1:0] CMD_NEIGHBOR = 2'd0;
    localparam logic [1:0] CMD_CLOSE    = 2'd1;
    localparam logic [1:0] CMD_START    = 2'd2;

    // Configuration port
    localparam int         CFG_ADDR_W     = 3;
    localparam int         CFG_DATA_W     = 32;
    localparam logic       REG_NODE_COUNT = 1'b0;
    localparam int         NODE_COUNT_W   = 11;
    localparam logic [10:0] NODE_COUNT_RST = 11'd1024;

    localparam int COLOR_W = 6;
    localparam int INDEX_W = 10;

    typedef struct packed {
        logic [1:0]         command;
        logic [INDEX_W-1:0] neighbor_index;
        logic               last_neighbor;
    } t_in_item;

    typedef struct packed {
        logic [INDEX_W-1:0] node_index;
        logic [COLOR_W-1:0] assigned_color;
        logic               color_overflow;
        logic               bad_neighbor;
        logic               final_node;
    } t_out_item;

    // Color store write request (address travels separately, width varies)
    typedef struct packed {
        logic               en;
        logic [COLOR_W-1:0] color;
    } t_store_wr;

endpackage

FILE: hw/rtl/ggc_cfg.sv
// Configuration register file (node_count) behind an APB-style port.
`timescale 1ns / 1ps

module ggc_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ggc_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [ggc_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [ggc_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                pready,
    output logic [ggc_pkg::NODE_COUNT_W-1:0]    o_node_count
);

    logic [ggc_pkg::NODE_COUNT_W-1:0] r_node_count;
    logic                             wr_hit;

    // register index sits above the byte offset
    assign wr_hit = psel && penable && pwrite && (paddr[2] == ggc_pkg::REG_NODE_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= ggc_pkg::NODE_COUNT_RST;
        end else if (wr_hit) begin
            r_node_count <= pwdata[ggc_pkg::NODE_COUNT_W-1:0];
        end
    end

    // read back; unused index reads zero
    always_comb begin
        if (paddr[2] == ggc_pkg::REG_NODE_COUNT) begin
            prdata = ggc_pkg::CFG_DATA_W'(r_node_count);
        end else begin
            prdata = '0;
        end
    end

    assign pready       = 1'b1;
    assign o_node_count = r_node_count;

endmodule

FILE: hw/rtl/ggc_store.sv
// Color store: one write and one registered read per cycle, with write bypass.
`timescale 1ns / 1ps

module ggc_store #(
    parameter int MAX_NODES = 1024,
    localparam int ADDR_W   = $clog2(MAX_NODES)
) (
    input  logic                        i_clk,
    input  logic                        i_rd_en,
    input  logic [ADDR_W-1:0]           i_rd_addr,
    input  ggc_pkg::t_store_wr          i_wr,
    input  logic [ADDR_W-1:0]           i_wr_addr,
    output logic [ggc_pkg::COLOR_W-1:0] o_rd_color
);

    logic [ggc_pkg::COLOR_W-1:0] mem [MAX_NODES];
    logic [ggc_pkg::COLOR_W-1:0] r_rd_color;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr_addr] <= i_wr.color;
        end
    end

    // read port; a write to the same entry on this edge is forwarded
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr.en && (i_wr_addr == i_rd_addr)) begin
                r_rd_color <= i_wr.color;
            end else begin
                r_rd_color <= mem[i_rd_addr];
            end
        end
    end

    assign o_rd_color = r_rd_color;

endmodule

FILE: hw/rtl/ggc_color.sv
// Coloring state and per-transaction color selection.
`timescale 1ns / 1ps
`include "greedy_graph_coloring_top_macros.svh"

module ggc_color #(
    parameter int MAX_NODES  = 1024,
    parameter int MAX_COLORS = 64,
    localparam int NODE_W    = $clog2(MAX_NODES)
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_adv,
    input  ggc_pkg::t_in_item                i_item,
    input  logic [ggc_pkg::COLOR_W-1:0]      i_rd_color,
    input  logic [ggc_pkg::NODE_COUNT_W-1:0] i_node_count,
    output logic                             o_res_valid,
    output ggc_pkg::t_out_item               o_result,
    output ggc_pkg::t_store_wr               o_wr,
    output logic [NODE_W-1:0]                o_wr_addr
);

    logic [NODE_W-1:0]     r_cur, n_cur;
    logic [MAX_COLORS-1:0] r_mask, n_mask;
    logic                  r_bad, n_bad;

    logic                  is_nb, is_close, is_start;
    logic [31:0]           idx32, cur32, cnt32;
    logic                  in_range, colored;
    logic [MAX_COLORS-1:0] hit, mask_nb;
    logic                  bad_nb;
    logic [ggc_pkg::COLOR_W-1:0] pick;
    logic                  ovf, final_flag, wrap;

    // decode
    assign is_nb    = (i_item.command == ggc_pkg::CMD_NEIGHBOR);
    assign is_close = (is_nb && i_item.last_neighbor) || (i_item.command == ggc_pkg::CMD_CLOSE);
    assign is_start = (i_item.command == ggc_pkg::CMD_START);

    // nodes are colored in index order, so colored means below the current node
    assign idx32    = 32'(i_item.neighbor_index);
    assign cur32    = 32'(r_cur);
    assign cnt32    = 32'(i_node_count);
    assign in_range = (idx32 < cnt32) && (idx32 < MAX_NODES);
    assign colored  = idx32 < cur32;

    // mark the neighbor's color
    always_comb begin
        for (int c = 0; c < MAX_COLORS; c++) begin
            hit[c] = (i_rd_color == ggc_pkg::COLOR_W'(c));
        end
    end

    assign mask_nb = (is_nb && in_range && colored) ? (r_mask | hit) : r_mask;
    assign bad_nb  = r_bad | (is_nb && !in_range);

    // lowest unused color, saturating when all are used
    always_comb begin
        pick = ggc_pkg::COLOR_W'(MAX_COLORS - 1);
        ovf  = 1'b1;
        for (int c = MAX_COLORS - 1; c >= 0; c--) begin
            if (!mask_nb[c]) begin
                pick = ggc_pkg::COLOR_W'(c);
                ovf  = 1'b0;
            end
        end
    end

    assign final_flag = (i_node_count != '0) && (cur32 == (cnt32 - 32'd1));
    assign wrap       = (cur32 + 32'd1) >= MAX_NODES;

    // next state
    always_comb begin
        n_cur  = r_cur;
        n_mask = r_mask;
        n_bad  = r_bad;
        priority if (is_start) begin
            n_cur  = '0;
            n_mask = '0;
            n_bad  = 1'b0;
        end else if (is_close) begin
            n_cur  = (final_flag || wrap) ? '0 : NODE_W'(cur32 + 32'd1);
            n_mask = '0;
            n_bad  = 1'b0;
        end else if (is_nb) begin
            n_mask = mask_nb;
            n_bad  = bad_nb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur  <= '0;
            r_mask <= '0;
            r_bad  <= 1'b0;
        end else if (i_adv) begin
            r_cur  <= n_cur;
            r_mask <= n_mask;
            r_bad  <= n_bad;
        end
    end

    // result and store write
    assign o_res_valid              = is_close;
    assign o_result.node_index      = ggc_pkg::INDEX_W'(cur32);
    assign o_result.assigned_color  = pick;
    assign o_result.color_overflow  = ovf;
    assign o_result.bad_neighbor    = bad_nb;
    assign o_result.final_node      = final_flag;
    assign o_wr.en                  = i_adv && is_close;
    assign o_wr.color               = pick;
    assign o_wr_addr                = r_cur;

    `GGC_ASSERT_NXT(a_start_clears, i_clk, i_rst_n, i_adv && is_start, (r_cur == '0) && (r_mask == '0))
    `GGC_ASSERT_NXT(a_final_restarts, i_clk, i_rst_n, i_adv && is_close && final_flag, r_cur == '0)
    `GGC_ASSERT_NXT(a_hold_when_idle, i_clk, i_rst_n, !i_adv, $stable(r_cur) && $stable(r_mask))

endmodule

FILE: hw/rtl/greedy_graph_coloring_top.sv
// Greedy sequential graph coloring: top level with handshakes and output register.
`timescale 1ns / 1ps
`include "greedy_graph_coloring_top_macros.svh"

// Input channel (i_in_valid / o_in_stall / i_in_data) takes, unless stalled, one
// transaction per cycle: a neighbor of the current node, a close of a node, or a
// graph start. Output channel (o_out_valid / i_out_stall / o_out_data) gives one
// colored node for each transaction that closes a node; others give nothing.
// Nodes are colored in index order from 0; after the final node (node_count-1)
// the block starts a new graph by itself.
// A result passes through the input stage, loaded with the color store read when
// its transaction is accepted, and then the output register. Throughput: one
// transaction per cycle while not stalled; the color store does one read and one
// write per cycle and the color pick is one priority encode. A stalled output
// holds its result; neighbor transactions keep flowing, and a closing transaction
// waits in the input stage until the output register frees. Reset clears the
// coloring state and sets node_count to 1024; no clearing pass is needed.
// node_count is written over the APB port (address 0); the user must do so only
// while idle, and the block itself does not enforce it.

module greedy_graph_coloring_top #(
    parameter int MAX_NODES  = 1024,
    parameter int MAX_COLORS = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input channel
    input  logic                               i_in_valid,
    input  ggc_pkg::t_in_item                  i_in_data,
    output logic                               o_in_stall,
    // output channel
    output logic                               o_out_valid,
    output ggc_pkg::t_out_item                 o_out_data,
    input  logic                               i_out_stall,
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ggc_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [ggc_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [ggc_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                               pready
);

    localparam int NODE_W = $clog2(MAX_NODES);

    logic                             r_s1_valid;
    ggc_pkg::t_in_item                r_s1_item;
    logic                             r_out_valid;
    ggc_pkg::t_out_item               r_out_data;

    logic                             in_acc, s1_adv, out_free, res_valid;
    logic [ggc_pkg::NODE_COUNT_W-1:0] node_count;
    logic [ggc_pkg::COLOR_W-1:0]      rd_color;
    ggc_pkg::t_out_item               result;
    ggc_pkg::t_store_wr               st_wr;
    logic [NODE_W-1:0]                wr_addr;
    logic [NODE_W-1:0]                rd_addr;

    // handshake control
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_adv     = r_s1_valid && (!res_valid || out_free);
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign rd_addr    = NODE_W'(32'(i_in_data.neighbor_index));

    ggc_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_node_count (node_count)
    );

    ggc_store #(
        .MAX_NODES (MAX_NODES)
    ) u_store (
        .i_clk      (i_clk),
        .i_rd_en    (in_acc),
        .i_rd_addr  (rd_addr),
        .i_wr       (st_wr),
        .i_wr_addr  (wr_addr),
        .o_rd_color (rd_color)
    );

    ggc_color #(
        .MAX_NODES  (MAX_NODES),
        .MAX_COLORS (MAX_COLORS)
    ) u_color (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (s1_adv),
        .i_item       (r_s1_item),
        .i_rd_color   (rd_color),
        .i_node_count (node_count),
        .o_res_valid  (res_valid),
        .o_result     (result),
        .o_wr         (st_wr),
        .o_wr_addr    (wr_addr)
    );

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_item <= i_in_data;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && res_valid) begin
            r_out_data <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `GGC_ASSERT_IMP(a_stall_needs_item, i_clk, i_rst_n, o_in_stall, r_s1_valid)
    `GGC_ASSERT_IMP(a_close_waits, i_clk, i_rst_n, r_s1_valid && res_valid && r_out_valid && i_out_stall, o_in_stall)
    `GGC_ASSERT_NXT(a_result_loaded, i_clk, i_rst_n, s1_adv && res_valid, r_out_valid)

endmodule
